FILE: src/sdgt_pkg.sv
package sdgt_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   localparam logic [2:0] STATUS_HIT     = 3'd0;
   localparam logic [2:0] STATUS_MISS    = 3'd1;
   localparam logic [2:0] STATUS_BEYOND  = 3'd2;
   localparam logic [2:0] STATUS_EMPTY   = 3'd3;
   localparam logic [2:0] STATUS_WRITTEN = 3'd4;

   localparam logic ACTION_LOAD      = 1'b0;
   localparam logic ACTION_TRANSLATE = 1'b1;

   localparam logic [1:0] CSR_CLUSTER_SHIFT  = 2'd0;
   localparam logic [1:0] CSR_TABLE_SHIFT    = 2'd1;
   localparam logic [1:0] CSR_DIRECTORY_SIZE = 2'd2;

   localparam logic [4:0]  CLUSTER_SHIFT_RESET  = 5'd7;
   localparam logic [3:0]  TABLE_SHIFT_RESET    = 4'd9;
   localparam logic [10:0] DIRECTORY_SIZE_RESET = 11'd0;

   localparam logic [31:0] COUNT_ALL_ONES = 32'hffff_ffff;

endpackage

FILE: src/sdgt_ram.sv
module sdgt_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [WIDTH-1:0]  write_data,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

FILE: src/sparse_disk_grain_translator.sv
// Sparse-disk grain translator front end. An item is taken at a clock edge with start
// high and busy low. A load item writes one directory word and answers status written
// in the very next cycle, so load items may follow one another every cycle. A translate
// item splits the sector into directory index, entry index and sector-in-cluster, reads
// the directory word from its RAM and then walks the tag store one way per cycle, looking
// for a matching tag and the least-used slot at once; the use counts are updated in a
// final cycle. A translate that reaches the tag store keeps busy high through the decode,
// read, scan and update states, and the result strobe comes in the cycle after the
// update state. A translate beyond the directory keeps busy high for one cycle and one
// through an empty directory word through its decode and read states, each with its
// strobe in the cycle after. rsp_valid is high for exactly one cycle per item and the
// receiver cannot stall it, so results must be taken as they come; a new item may be
// offered in the very cycle the strobe is shown. The directory holds no reset value and
// needs no clearing pass: translating through a word never loaded gives an undefined
// answer. Configuration may be written only while the block is idle.
module sparse_disk_grain_translator #(
   parameter int DIR_DEPTH = 1024,
   parameter int WAYS      = 16
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     start,
   output logic                     busy,
   input  logic                     req_action,
   input  logic [9:0]               req_dir_slot,
   input  logic [31:0]              req_dir_word,
   input  logic [31:0]              req_sector,

   output logic                     rsp_valid,
   output logic [2:0]               rsp_status,
   output logic [$clog2(WAYS)-1:0]  rsp_way,
   output logic [31:0]              rsp_table_location,
   output logic [11:0]              rsp_entry_index,
   output logic [15:0]              rsp_offset_in_cluster,

   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [10:0]              csr_write_data
);

   localparam int WAY_W  = $clog2(WAYS);
   localparam int ADDR_W = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;

   // sequencer and item registers
   sdgt_pkg::state_type state_ff, state_in;
   logic [31:0]      sector_ff, sector_in;
   logic [31:0]      loc_ff, loc_in;
   logic [WAY_W-1:0] scan_ff, scan_in;
   logic             hit_found_ff, hit_found_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in;
   logic [31:0]      min_count_ff, min_count_in;
   logic [WAY_W-1:0] victim_ff, victim_in;

   // tag store
   logic [31:0] tags_ff   [WAYS];
   logic [31:0] tags_in   [WAYS];
   logic [31:0] counts_ff [WAYS];
   logic [31:0] counts_in [WAYS];

   // configuration
   logic [4:0]  cluster_shift_ff;
   logic [3:0]  table_shift_ff;
   logic [10:0] directory_size_ff;

   // result registers
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [WAY_W-1:0] rsp_way_ff, rsp_way_in;
   logic [31:0]      rsp_loc_ff, rsp_loc_in;
   logic [11:0]      rsp_entry_ff, rsp_entry_in;
   logic [15:0]      rsp_offs_ff, rsp_offs_in;

   // directory ram
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_raddr;
   logic [31:0]       ram_rdata;

   // index split
   logic [5:0]  shift_total;
   logic [31:0] dir_index;
   logic [31:0] entry_wide;
   logic [31:0] offs_wide;
   logic [31:0] slot_wide;
   logic        beyond;
   logic        slot_ok;
   logic        accept;
   logic [31:0] hit_inc;

   assign accept      = start && (state_ff == sdgt_pkg::ST_IDLE);
   assign busy        = (state_ff != sdgt_pkg::ST_IDLE);

   // shifts of 32 or more come out as zero
   assign shift_total = 6'(cluster_shift_ff) + 6'(table_shift_ff);
   assign dir_index   = sector_ff >> shift_total;
   assign entry_wide  = (sector_ff >> cluster_shift_ff)
                        & ((32'd1 << table_shift_ff) - 32'd1);
   assign offs_wide   = sector_ff & ((32'd1 << cluster_shift_ff) - 32'd1);
   assign beyond      = (dir_index >= 32'(directory_size_ff))
                        || (dir_index >= 32'(DIR_DEPTH));

   assign slot_wide   = 32'(req_dir_slot);
   assign slot_ok     = slot_wide < 32'(DIR_DEPTH);
   assign ram_waddr   = slot_wide[ADDR_W-1:0];
   assign ram_raddr   = dir_index[ADDR_W-1:0];
   assign ram_we      = accept && (req_action == sdgt_pkg::ACTION_LOAD) && slot_ok;

   assign hit_inc     = counts_ff[hit_way_ff] + 32'd1;

   sdgt_ram #(
      .WIDTH (32),
      .DEPTH (DIR_DEPTH)
   ) u_directory (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (req_dir_word),
      .read_addr    (ram_raddr),
      .read_data    (ram_rdata)
   );

   // configuration writes, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_shift_ff  <= sdgt_pkg::CLUSTER_SHIFT_RESET;
         table_shift_ff    <= sdgt_pkg::TABLE_SHIFT_RESET;
         directory_size_ff <= sdgt_pkg::DIRECTORY_SIZE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sdgt_pkg::CSR_CLUSTER_SHIFT:  cluster_shift_ff  <= csr_write_data[4:0];
            sdgt_pkg::CSR_TABLE_SHIFT:    table_shift_ff    <= csr_write_data[3:0];
            sdgt_pkg::CSR_DIRECTORY_SIZE: directory_size_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // control state and tag store
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdgt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WAYS; i++) begin
            tags_ff[i]   <= '0;
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < WAYS; i++) begin
            tags_ff[i]   <= tags_in[i];
            counts_ff[i] <= counts_in[i];
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      sector_ff     <= sector_in;
      loc_ff        <= loc_in;
      scan_ff       <= scan_in;
      hit_found_ff  <= hit_found_in;
      hit_way_ff    <= hit_way_in;
      min_count_ff  <= min_count_in;
      victim_ff     <= victim_in;
      rsp_status_ff <= rsp_status_in;
      rsp_way_ff    <= rsp_way_in;
      rsp_loc_ff    <= rsp_loc_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_offs_ff   <= rsp_offs_in;
   end

   always_comb begin
      state_in      = state_ff;
      sector_in     = sector_ff;
      loc_in        = loc_ff;
      scan_in       = scan_ff;
      hit_found_in  = hit_found_ff;
      hit_way_in    = hit_way_ff;
      min_count_in  = min_count_ff;
      victim_in     = victim_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_way_in    = rsp_way_ff;
      rsp_loc_in    = rsp_loc_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_offs_in   = rsp_offs_ff;
      for (int i = 0; i < WAYS; i++) begin
         tags_in[i]   = tags_ff[i];
         counts_in[i] = counts_ff[i];
      end

      unique case (state_ff)
         sdgt_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_action == sdgt_pkg::ACTION_LOAD) begin
                  // directory word goes straight into the ram
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = sdgt_pkg::STATUS_WRITTEN;
                  rsp_way_in    = '0;
                  rsp_loc_in    = '0;
                  rsp_entry_in  = '0;
                  rsp_offs_in   = '0;
               end else begin
                  sector_in = req_sector;
                  state_in  = sdgt_pkg::ST_DECODE;
               end
            end
         end

         sdgt_pkg::ST_DECODE: begin
            // indices are reported whatever the outcome
            rsp_entry_in = entry_wide[11:0];
            rsp_offs_in  = offs_wide[15:0];
            if (beyond) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sdgt_pkg::STATUS_BEYOND;
               rsp_way_in    = '0;
               rsp_loc_in    = '0;
               state_in      = sdgt_pkg::ST_IDLE;
            end else begin
               state_in = sdgt_pkg::ST_READ;
            end
         end

         sdgt_pkg::ST_READ: begin
            if (ram_rdata == 32'd0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sdgt_pkg::STATUS_EMPTY;
               rsp_way_in    = '0;
               rsp_loc_in    = '0;
               state_in      = sdgt_pkg::ST_IDLE;
            end else begin
               loc_in       = ram_rdata;
               scan_in      = '0;
               hit_found_in = 1'b0;
               hit_way_in   = '0;
               min_count_in = sdgt_pkg::COUNT_ALL_ONES;
               victim_in    = '0;
               state_in     = sdgt_pkg::ST_SCAN;
            end
         end

         sdgt_pkg::ST_SCAN: begin
            // first matching tag wins, first strictly lowest count is the victim
            if (!hit_found_ff && (tags_ff[scan_ff] == loc_ff)) begin
               hit_found_in = 1'b1;
               hit_way_in   = scan_ff;
            end
            if (counts_ff[scan_ff] < min_count_ff) begin
               min_count_in = counts_ff[scan_ff];
               victim_in    = scan_ff;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == WAY_W'(WAYS - 1)) begin
               state_in = sdgt_pkg::ST_UPDATE;
            end
         end

         sdgt_pkg::ST_UPDATE: begin
            rsp_valid_in = 1'b1;
            rsp_loc_in   = loc_ff;
            state_in     = sdgt_pkg::ST_IDLE;
            if (hit_found_ff) begin
               rsp_status_in = sdgt_pkg::STATUS_HIT;
               rsp_way_in    = hit_way_ff;
               if (hit_inc == sdgt_pkg::COUNT_ALL_ONES) begin
                  // saturating count: halve every slot
                  for (int i = 0; i < WAYS; i++) begin
                     if (WAY_W'(i) == hit_way_ff) begin
                        counts_in[i] = hit_inc >> 1;
                     end else begin
                        counts_in[i] = counts_ff[i] >> 1;
                     end
                  end
               end else begin
                  counts_in[hit_way_ff] = hit_inc;
               end
            end else begin
               rsp_status_in        = sdgt_pkg::STATUS_MISS;
               rsp_way_in           = victim_ff;
               tags_in[victim_ff]   = loc_ff;
               counts_in[victim_ff] = 32'd1;
            end
         end

         default: begin
            state_in = sdgt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_way               = rsp_way_ff;
   assign rsp_table_location    = rsp_loc_ff;
   assign rsp_entry_index       = rsp_entry_ff;
   assign rsp_offset_in_cluster = rsp_offs_ff;

endmodule

FILE: test/sdgt_grain_checker.sv
`timescale 1ns / 100ps

module sdgt_grain_checker #(
   parameter int DIR_DEPTH = 1024,
   parameter int WAYS      = 16,
   parameter int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic             clock,
   input  logic             reset,

   input  logic             start,
   input  logic             busy,
   input  logic             req_action,
   input  logic [9:0]       req_dir_slot,
   input  logic [31:0]      req_dir_word,
   input  logic [31:0]      req_sector,

   input  logic             rsp_valid,
   input  logic [2:0]       rsp_status,
   input  logic [WAY_W-1:0] rsp_way,
   input  logic [31:0]      rsp_table_location,
   input  logic [11:0]      rsp_entry_index,
   input  logic [15:0]      rsp_offset_in_cluster,

   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [10:0]      csr_write_data,

   output int               mismatches,
   output int               awaited,
   output int               hits,
   output int               replacements
);

   typedef struct packed {
      logic [2:0]       status;
      logic [WAY_W-1:0] way;
      logic [31:0]      location;
      logic [11:0]      entry;
      logic [15:0]      offset;
   } grain_answer_type;

   logic [31:0]      directory [DIR_DEPTH];
   logic [31:0]      tags      [WAYS];
   logic [31:0]      counts    [WAYS];
   logic [4:0]       cluster_shift;
   logic [3:0]       table_shift;
   logic [10:0]      directory_size;
   grain_answer_type answers_due [$];

   function automatic grain_answer_type translate_item(input logic act,
                                                       input logic [9:0] slot,
                                                       input logic [31:0] word,
                                                       input logic [31:0] sector);
      grain_answer_type a;
      logic [63:0]      dir_index;
      logic [31:0]      lowest;
      int               shift;
      int               hit_way;
      int               victim;
      a = '0;
      if (act == sdgt_pkg::ACTION_LOAD) begin
         if (slot < DIR_DEPTH) directory[slot] = word;
         a.status = sdgt_pkg::STATUS_WRITTEN;
         return a;
      end
      shift     = int'(cluster_shift) + int'(table_shift);
      dir_index = {32'd0, sector} >> shift;
      a.entry   = 12'(({32'd0, sector} >> cluster_shift) & ((64'd1 << table_shift) - 64'd1));
      a.offset  = 16'({32'd0, sector} & ((64'd1 << cluster_shift) - 64'd1));
      if (dir_index >= directory_size || dir_index >= DIR_DEPTH) begin
         a.status = sdgt_pkg::STATUS_BEYOND;
      end else if (directory[dir_index] == 32'd0) begin
         a.status = sdgt_pkg::STATUS_EMPTY;
      end else begin
         a.location = directory[dir_index];
         hit_way    = -1;
         for (int i = 0; i < WAYS; i++)
            if (hit_way < 0 && tags[i] == a.location) hit_way = i;
         if (hit_way >= 0) begin
            counts[hit_way] += 32'd1;
            // saturating count ages the whole set
            if (counts[hit_way] == sdgt_pkg::COUNT_ALL_ONES)
               for (int i = 0; i < WAYS; i++) counts[i] >>= 1;
            a.status = sdgt_pkg::STATUS_HIT;
            a.way    = WAY_W'(hit_way);
         end else begin
            victim = 0;
            lowest = sdgt_pkg::COUNT_ALL_ONES;
            for (int i = 0; i < WAYS; i++) begin
               if (counts[i] < lowest) begin
                  lowest = counts[i];
                  victim = i;
               end
            end
            tags[victim]   = a.location;
            counts[victim] = 32'd1;
            a.status       = sdgt_pkg::STATUS_MISS;
            a.way          = WAY_W'(victim);
         end
      end
      return a;
   endfunction

   function automatic int field_mismatch(input string name, input logic [31:0] expected,
                                         input logic [31:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      grain_answer_type due;
      if (reset) begin
         cluster_shift  = sdgt_pkg::CLUSTER_SHIFT_RESET;
         table_shift    = sdgt_pkg::TABLE_SHIFT_RESET;
         directory_size = sdgt_pkg::DIRECTORY_SIZE_RESET;
         for (int i = 0; i < WAYS; i++) begin
            tags[i]   = 32'd0;
            counts[i] = 32'd0;
         end
         answers_due.delete();
      end else begin
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               $error("result with status %0d arrived with no item outstanding", rsp_status);
               mismatches++;
            end else begin
               due = answers_due.pop_front();
               mismatches += field_mismatch("status", 32'(due.status), 32'(rsp_status))
                           + field_mismatch("way", 32'(due.way), 32'(rsp_way))
                           + field_mismatch("table_location", due.location,
                                            rsp_table_location)
                           + field_mismatch("entry_index", 32'(due.entry),
                                            32'(rsp_entry_index))
                           + field_mismatch("offset_in_cluster", 32'(due.offset),
                                            32'(rsp_offset_in_cluster));
            end
         end
         if (start && !busy) begin
            due = translate_item(req_action, req_dir_slot, req_dir_word, req_sector);
            if (due.status == sdgt_pkg::STATUS_HIT) hits++;
            if (due.status == sdgt_pkg::STATUS_MISS) replacements++;
            answers_due.push_back(due);
         end
         if (csr_write_enable) begin
            case (csr_index)
               sdgt_pkg::CSR_CLUSTER_SHIFT:  cluster_shift  = csr_write_data[4:0];
               sdgt_pkg::CSR_TABLE_SHIFT:    table_shift    = csr_write_data[3:0];
               sdgt_pkg::CSR_DIRECTORY_SIZE: directory_size = csr_write_data;
               default: ;
            endcase
         end
      end
      awaited = answers_due.size();
   end

endmodule

FILE: test/sparse_disk_grain_translator_tb.sv
`timescale 1ns / 100ps

module sparse_disk_grain_translator_tb;

   localparam int         DIR_DEPTH    = 1024;
   localparam int         WAYS         = 16;
   localparam int         WAY_W        = $clog2(WAYS);
   localparam logic [1:0] CSR_SPARE    = 2'd3;   // unmapped index, writes must change nothing
   localparam int         POOL_SIZE    = 24;     // more table locations than ways
   localparam int         PHASES       = 9;
   localparam int         RANDOM_ITEMS = 450;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic             req_action = sdgt_pkg::ACTION_LOAD;
   logic [9:0]       req_dir_slot = '0;
   logic [31:0]      req_dir_word = '0;
   logic [31:0]      req_sector = '0;
   logic             rsp_valid;
   logic [2:0]       rsp_status;
   logic [WAY_W-1:0] rsp_way;
   logic [31:0]      rsp_table_location;
   logic [11:0]      rsp_entry_index;
   logic [15:0]      rsp_offset_in_cluster;
   logic             csr_write_enable = 1'b0;
   logic [1:0]       csr_index = sdgt_pkg::CSR_CLUSTER_SHIFT;
   logic [10:0]      csr_write_data = '0;

   int mismatches;
   int awaited;
   int hits;
   int replacements;

   // stimulus-side view of the block, used only to shape items
   int             cfg_cluster_shift  = int'(sdgt_pkg::CLUSTER_SHIFT_RESET);
   int             cfg_table_shift    = int'(sdgt_pkg::TABLE_SHIFT_RESET);
   int             cfg_directory_size = int'(sdgt_pkg::DIRECTORY_SIZE_RESET);
   bit             loaded [DIR_DEPTH];
   logic [31:0]    pool [POOL_SIZE];
   bit             idling;
   int             load_count;
   int             translate_count;
   int             setting_count;

   // fixed settings for the first random phases, extremes included
   int phase_cs [6] = '{7, 0, 16, 3, 10, 0};
   int phase_ts [6] = '{9, 0, 12, 5, 2, 12};
   int phase_ds [6] = '{1024, 1024, 1024, 37, 1, 0};

   sparse_disk_grain_translator #(
      .DIR_DEPTH (DIR_DEPTH),
      .WAYS      (WAYS)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_action            (req_action),
      .req_dir_slot          (req_dir_slot),
      .req_dir_word          (req_dir_word),
      .req_sector            (req_sector),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_way               (rsp_way),
      .rsp_table_location    (rsp_table_location),
      .rsp_entry_index       (rsp_entry_index),
      .rsp_offset_in_cluster (rsp_offset_in_cluster),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   sdgt_grain_checker #(
      .DIR_DEPTH (DIR_DEPTH),
      .WAYS      (WAYS)
   ) grain_checker (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_action            (req_action),
      .req_dir_slot          (req_dir_slot),
      .req_dir_word          (req_dir_word),
      .req_sector            (req_sector),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_way               (rsp_way),
      .rsp_table_location    (rsp_table_location),
      .rsp_entry_index       (rsp_entry_index),
      .rsp_offset_in_cluster (rsp_offset_in_cluster),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .mismatches            (mismatches),
      .awaited               (awaited),
      .hits                  (hits),
      .replacements          (replacements)
   );

   always #2 clock = ~clock;

   // hard stop, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // offer one item and hold it until taken, then maybe leave a gap
   task automatic drive_item(input logic act, input logic [9:0] slot, input logic [31:0] word,
                             input logic [31:0] sector);
      @(negedge clock);
      start        <= 1'b1;
      req_action   <= act;
      req_dir_slot <= slot;
      req_dir_word <= word;
      req_sector   <= sector;
      do begin
         @(posedge clock);
      end while (busy);
      if (act == sdgt_pkg::ACTION_LOAD) load_count++;
      else translate_count++;
      if (idling && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 11)) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
   endtask

   // mostly a few hot locations, sometimes empty or arbitrary words
   function automatic logic [31:0] pick_location();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 32'd0;
      if (r < 20) return $urandom;
      if (r < 60) return pool[$urandom_range(0, 7)];
      return pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   task automatic load_slot(input logic [9:0] slot, input logic [31:0] word);
      loaded[slot] = 1'b1;
      drive_item(sdgt_pkg::ACTION_LOAD, slot, word, $urandom);
   endtask

   // a translate never lands on a directory word that was never loaded
   task automatic translate_sector(input logic [31:0] sector);
      longint idx;
      idx = longint'({32'd0, sector} >> (cfg_cluster_shift + cfg_table_shift));
      if (idx < cfg_directory_size && idx < DIR_DEPTH && !loaded[idx])
         load_slot(idx[9:0], pick_location());
      drive_item(sdgt_pkg::ACTION_TRANSLATE, 10'($urandom), $urandom, sector);
   endtask

   // sector whose directory index is idx, with random entry and offset bits
   function automatic logic [31:0] sector_in_entry(input int idx);
      int          shift;
      logic [63:0] s;
      shift = cfg_cluster_shift + cfg_table_shift;
      s = (64'(idx) << shift) | (64'($urandom) & ((64'd1 << shift) - 64'd1));
      return s[31:0];
   endfunction

   // wait for every outstanding result with nothing offered
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (awaited != 0 || busy) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [10:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
   endtask

   // registers only change with the block idle
   task automatic apply_setting(input int cs, input int ts, input int ds);
      drain();
      csr_write(sdgt_pkg::CSR_CLUSTER_SHIFT, 11'(cs));
      csr_write(sdgt_pkg::CSR_TABLE_SHIFT, 11'(ts));
      csr_write(sdgt_pkg::CSR_DIRECTORY_SIZE, 11'(ds));
      csr_write(CSR_SPARE, 11'($urandom));
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_cluster_shift  = cs;
      cfg_table_shift    = ts;
      cfg_directory_size = ds;
      setting_count++;
   endtask

   task automatic random_run(input int count);
      int     r;
      int     idx;
      int     hot;
      longint limit;
      for (int n = 0; n < count; n++) begin
         // entries a translate can actually reach under the present setting
         limit = (cfg_directory_size < DIR_DEPTH) ? cfg_directory_size : DIR_DEPTH;
         if ((64'hffff_ffff >> (cfg_cluster_shift + cfg_table_shift)) + 1 < limit)
            limit = (64'hffff_ffff >> (cfg_cluster_shift + cfg_table_shift)) + 1;
         hot = (limit < 32) ? int'(limit) : 32;
         r   = $urandom_range(0, 99);
         if (r < 30) begin
            if (limit > 0 && $urandom_range(0, 1) == 1) idx = $urandom_range(0, hot - 1);
            else idx = $urandom_range(0, DIR_DEPTH - 1);
            load_slot(idx[9:0], pick_location());
         end else if (r < 80 && limit > 0) begin
            // favour a handful of entries so the tag store sees repeats
            if ($urandom_range(0, 2) != 0) idx = $urandom_range(0, hot - 1);
            else idx = $urandom_range(0, int'(limit) - 1);
            translate_sector(sector_in_entry(idx));
         end else begin
            case ($urandom_range(0, 7))
               0:       translate_sector(32'h0000_0000);
               1:       translate_sector(32'hffff_ffff);
               default: translate_sector($urandom);
            endcase
         end
      end
   endtask

   initial begin
      pool[0] = 32'hffff_ffff;
      pool[1] = 32'h0000_0001;
      for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom | 32'h1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting, directory size zero: every translate is beyond it
      translate_sector(32'h0000_0000);
      translate_sector(32'hffff_ffff);

      // no shift at all: the sector is the directory index
      apply_setting(0, 0, DIR_DEPTH);
      load_slot(10'd0, 32'h0000_0000);
      translate_sector(32'd0);              // empty directory word
      load_slot(10'd1023, 32'hffff_ffff);
      translate_sector(32'd1023);           // first use, replaces a way
      translate_sector(32'd1023);           // same table again, hit
      translate_sector(32'd1024);           // one past the directory
      load_slot(10'd1, 32'h0000_0001);
      translate_sector(32'd1);

      // widest shifts: entry and offset fields at their top
      apply_setting(16, 12, DIR_DEPTH);
      load_slot(10'd15, pool[2]);
      translate_sector(32'hffff_ffff);
      translate_sector(32'hf000_0000);
      translate_sector(32'h0000_0000);      // slot 0 still empty

      // a single directory entry
      apply_setting(int'(sdgt_pkg::CLUSTER_SHIFT_RESET), int'(sdgt_pkg::TABLE_SHIFT_RESET), 1);
      translate_sector(32'h0000_ffff);
      translate_sector(32'h0001_0000);      // index equal to the directory size
      load_slot(10'd0, pool[0]);
      translate_sector(32'h0000_1234);      // location already tagged

      // random phases, the last one with the sender never pausing
      idling = 1'b1;
      for (int p = 0; p < PHASES; p++) begin
         if (p < 6) apply_setting(phase_cs[p], phase_ts[p], phase_ds[p]);
         else apply_setting($urandom_range(0, 16), $urandom_range(0, 12),
                            $urandom_range(0, DIR_DEPTH));
         if (p == PHASES - 1) idling = 1'b0;
         random_run(RANDOM_ITEMS / PHASES);
      end

      drain();
      // a stray late result would still be flagged by the checker
      repeat (40) @(posedge clock);

      $display("ran %0d load and %0d translate items across %0d register settings",
               load_count, translate_count, setting_count);
      $display("tag store saw %0d hits and %0d replacements", hits, replacements);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
